@@ rtl/link_reconnect_backoff_controller_assert.svh @@
// Assertion macros for the link reconnect controller
`ifndef LINK_RECONNECT_BACKOFF_CONTROLLER_ASSERT_SVH
`define LINK_RECONNECT_BACKOFF_CONTROLLER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LRB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define LRB_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define LRB_ASSERT_IMP(label, clk, rst_n, a, c)
`define LRB_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/lrbc_pkg.sv @@
// -----------------------------------------------------------------------------
// lrbc_pkg
// Types and constants shared by the reconnect controller modules.
// -----------------------------------------------------------------------------
package lrbc_pkg;
    localparam logic [2:0] M_INACTIVE     = 3'd0;
    localparam logic [2:0] M_CONNECTING   = 3'd1;
    localparam logic [2:0] M_ONLINE       = 3'd2;
    localparam logic [2:0] M_RETRYING     = 3'd3;
    localparam logic [2:0] M_PROVISIONING = 3'd4;

    localparam logic [1:0] ST_CONNECTED = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_AUTH_FAIL = 2'd2;
    localparam logic [1:0] ST_PENDING   = 2'd3;

    localparam logic       OP_START = 1'b0;

    localparam logic [2:0] R_LINK_ENABLED   = 3'd0;
    localparam logic [2:0] R_PROV_MODE      = 3'd1;
    localparam logic [2:0] R_FALLBACK_CH    = 3'd2;
    localparam logic [2:0] R_CONNECT_TO     = 3'd3;
    localparam logic [2:0] R_RECONNECT_TO   = 3'd4;
    localparam logic [2:0] R_PARK_RETRY     = 3'd5;
    localparam logic [2:0] R_BACKOFF_MIN    = 3'd6;
    localparam logic [2:0] R_BACKOFF_MAX    = 3'd7;

    localparam logic [7:0] ATTEMPT_MAX = 8'd255;
    localparam logic [3:0] CHAN_MAX    = 4'd13;

    typedef struct packed {
        logic        op;
        logic [31:0] now_ms;
        logic [1:0]  link_status;
        logic        channel_ok;
        logic [3:0]  radio_channel;
        logic        park_ok;
        logic [31:0] random_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  mode;
        logic        connect_request;
        logic [3:0]  connect_channel;
        logic        disconnect_request;
        logic        park_request;
        logic        responders_on;
        logic        channel_notify;
        logic [3:0]  notify_channel;
        logic [7:0]  attempt_count;
        logic [31:0] retry_delay_ms;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;      // evaluate item, latch results that need no divide
        logic bo_start;  // start backoff doubling
        logic bo_step;   // one doubling step
        logic div_start; // start jitter remainder
        logic div_step;  // one remainder bit
        logic commit;    // write retry delay
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_retry;
        logic bo_done;
        logic div_done;
    } t_sts;
endpackage

@@ rtl/lrbc_ctrl.sv @@
// -----------------------------------------------------------------------------
// lrbc_ctrl
// Sequencer: accept item, run backoff and jitter steps when a retry is needed, present result.
// -----------------------------------------------------------------------------
`include "link_reconnect_backoff_controller_assert.svh"
module lrbc_ctrl import lrbc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_BO, S_DIV, S_DONE} t_state;
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.need_retry) begin
                    o_cmd.bo_start = 1'b1;
                    n_state        = S_BO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BO: begin
                if (i_sts.bo_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.bo_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `LRB_ASSERT_NXT(a_load_eval, i_clk, i_rst_n, o_cmd.load, r_state == S_EVAL)
    `LRB_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_in_ready)
    `LRB_ASSERT_NXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, r_out_valid)
endmodule

@@ rtl/lrbc_datapath.sv @@
// -----------------------------------------------------------------------------
// lrbc_datapath
// Link state, timers, backoff doubling and bit-serial jitter remainder.
// -----------------------------------------------------------------------------
module lrbc_datapath import lrbc_pkg::*; #(
    parameter int TIMER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_in_item    i_in,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output t_out_item   o_out
);
    localparam int EW = (TIMER_BITS > 32) ? TIMER_BITS : 32;

    logic        r_link_en, r_prov;
    logic [3:0]  r_fb;
    logic [31:0] r_cto, r_rto, r_prt, r_bmin, r_bmax;

    logic [2:0]  r_mode;
    logic [7:0]  r_att;
    logic [3:0]  r_lrep, r_lon;
    logic        r_parked, r_pfail, r_resp;
    logic [TIMER_BITS-1:0] r_entered, r_park_at;
    logic [31:0] r_delay;

    t_in_item    r_in;
    t_out_item   r_out;

    logic [32:0] r_bo;
    logic [7:0]  r_bo_i;
    logic [7:0]  r_bo_n;
    logic [31:0] r_base, r_win1, r_rem, r_dq;
    logic [5:0]  r_dcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_en <= 1'b0;
            r_prov    <= 1'b0;
            r_fb      <= 4'd1;
            r_cto     <= 32'd15000;
            r_rto     <= 32'd8000;
            r_prt     <= 32'd5000;
            r_bmin    <= 32'd1000;
            r_bmax    <= 32'd60000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                R_LINK_ENABLED: r_link_en <= i_cfg_data[0];
                R_PROV_MODE:    r_prov    <= i_cfg_data[0];
                R_FALLBACK_CH:  r_fb      <= i_cfg_data[3:0];
                R_CONNECT_TO:   r_cto     <= i_cfg_data;
                R_RECONNECT_TO: r_rto     <= i_cfg_data;
                R_PARK_RETRY:   r_prt     <= i_cfg_data;
                R_BACKOFF_MIN:  r_bmin    <= i_cfg_data;
                R_BACKOFF_MAX:  r_bmax    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // evaluate one item from registered input
    logic [TIMER_BITS-1:0] now_t, el_park, el_mode;
    logic [EW-1:0] el_park_w, el_mode_w;
    logic rd_ok;
    logic [3:0] fb_ch;
    logic [2:0] n_mode;
    logic [7:0] n_att;
    logic [3:0] n_lrep, n_lon;
    logic n_parked, n_pfail, n_resp, n_need;
    logic [TIMER_BITS-1:0] n_entered, n_park_at;
    logic [31:0] n_delay;
    t_out_item n_out;
    logic [31:0] to_sel;

    always_comb begin
        now_t     = TIMER_BITS'(r_in.now_ms);
        el_park   = now_t - r_park_at;
        el_mode   = now_t - r_entered;
        el_park_w = EW'(el_park);
        el_mode_w = EW'(el_mode);
        rd_ok     = r_in.channel_ok && (r_in.radio_channel != 4'd0);
        fb_ch     = (r_fb < 4'd1 || r_fb > CHAN_MAX) ? 4'd1 : r_fb;
        to_sel    = (r_lon == 4'd0) ? r_cto : r_rto;
        n_mode = r_mode; n_att = r_att; n_lrep = r_lrep; n_lon = r_lon;
        n_parked = r_parked; n_pfail = r_pfail; n_resp = r_resp;
        n_entered = r_entered; n_park_at = r_park_at; n_delay = r_delay;
        n_need = 1'b0;
        n_out = '0;
        if (r_in.op == OP_START) begin
            n_resp = 1'b0;
            if (r_prov) begin
                n_out.disconnect_request = 1'b1;
                n_mode = M_PROVISIONING; n_entered = now_t;
                if (rd_ok && r_in.radio_channel != n_lrep) begin
                    n_lrep = r_in.radio_channel; n_out.channel_notify = 1'b1;
                    n_out.notify_channel = r_in.radio_channel;
                end
            end else begin
                n_att = '0; n_lrep = '0; n_lon = '0; n_parked = 1'b0; n_pfail = 1'b0;
                n_delay = r_bmin;
                if (!r_link_en) begin
                    n_out.disconnect_request = 1'b1;
                    n_park_at = now_t; n_out.park_request = 1'b1;
                    if (!r_in.park_ok) begin
                        n_parked = 1'b0; n_pfail = 1'b1;
                    end else begin
                        n_parked = rd_ok && r_in.radio_channel == fb_ch; n_pfail = 1'b0;
                    end
                    if (rd_ok && r_in.radio_channel != n_lrep) begin
                        n_lrep = r_in.radio_channel; n_out.channel_notify = 1'b1;
                        n_out.notify_channel = r_in.radio_channel;
                    end
                    n_mode = M_INACTIVE; n_entered = now_t;
                end else begin
                    n_parked = 1'b0;
                    if (n_att < ATTEMPT_MAX) n_att = n_att + 8'd1;
                    n_out.connect_request = 1'b1; n_out.connect_channel = n_lon;
                    n_mode = M_CONNECTING; n_entered = now_t;
                end
            end
        end else begin
            case (r_mode)
                M_PROVISIONING: begin
                    if (rd_ok && r_in.radio_channel != n_lrep) begin
                        n_lrep = r_in.radio_channel; n_out.channel_notify = 1'b1;
                        n_out.notify_channel = r_in.radio_channel;
                    end
                end
                M_INACTIVE, M_RETRYING: begin
                    if (!r_parked && el_park_w >= EW'(r_prt)) begin
                        n_park_at = now_t; n_out.park_request = 1'b1;
                        if (!r_in.park_ok) begin
                            n_parked = 1'b0; n_pfail = 1'b1;
                        end else begin
                            n_parked = rd_ok && r_in.radio_channel == fb_ch;
                            n_pfail = 1'b0;
                        end
                        if (rd_ok && r_in.radio_channel != n_lrep) begin
                            n_lrep = r_in.radio_channel; n_out.channel_notify = 1'b1;
                            n_out.notify_channel = r_in.radio_channel;
                        end
                    end
                    if (r_mode == M_RETRYING && el_mode_w >= EW'(r_delay)) begin
                        n_parked = 1'b0;
                        if (n_att < ATTEMPT_MAX) n_att = n_att + 8'd1;
                        n_out.connect_request = 1'b1; n_out.connect_channel = n_lon;
                        n_mode = M_CONNECTING; n_entered = now_t;
                    end
                end
                M_CONNECTING, M_ONLINE: begin
                    if (r_in.link_status == ST_CONNECTED) begin
                        if (rd_ok) n_lon = r_in.radio_channel;
                        if (r_mode == M_CONNECTING) begin
                            n_att = '0; n_mode = M_ONLINE; n_entered = now_t;
                            n_resp = 1'b1;
                        end
                        if (rd_ok && r_in.radio_channel != n_lrep) begin
                            n_lrep = r_in.radio_channel; n_out.channel_notify = 1'b1;
                            n_out.notify_channel = r_in.radio_channel;
                        end
                    end else if (r_mode == M_ONLINE
                                 || r_in.link_status == ST_NOT_FOUND
                                 || r_in.link_status == ST_AUTH_FAIL
                                 || el_mode_w >= EW'(to_sel)) begin
                        n_need = 1'b1;
                        n_out.disconnect_request = 1'b1; n_resp = 1'b0;
                        n_park_at = now_t; n_out.park_request = 1'b1;
                        if (!r_in.park_ok) begin
                            n_parked = 1'b0; n_pfail = 1'b1;
                        end else begin
                            n_parked = rd_ok && r_in.radio_channel == fb_ch;
                            n_pfail = 1'b0;
                        end
                        if (rd_ok && r_in.radio_channel != n_lrep) begin
                            n_lrep = r_in.radio_channel; n_out.channel_notify = 1'b1;
                            n_out.notify_channel = r_in.radio_channel;
                        end
                        n_mode = M_RETRYING; n_entered = now_t;
                    end
                end
                default: ;
            endcase
        end
        n_out.mode = n_mode;
        n_out.responders_on = n_resp;
        n_out.attempt_count = n_att;
        n_out.retry_delay_ms = n_delay;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
    end

    // mode state: written in the cycle after load, while in evaluation
    logic r_eval;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval    <= 1'b0;
            r_mode    <= M_INACTIVE;
            r_att     <= '0;
            r_lrep    <= '0;
            r_lon     <= '0;
            r_parked  <= 1'b0;
            r_pfail   <= 1'b0;
            r_resp    <= 1'b0;
            r_entered <= '0;
            r_park_at <= '0;
            r_delay   <= 32'd1000;
        end else begin
            r_eval <= i_cmd.load;
            if (r_eval) begin
                r_mode <= n_mode; r_att <= n_att; r_lrep <= n_lrep; r_lon <= n_lon;
                r_parked <= n_parked; r_pfail <= n_pfail; r_resp <= n_resp;
                r_entered <= n_entered; r_park_at <= n_park_at; r_delay <= n_delay;
            end
            if (i_cmd.commit) r_delay <= r_base - r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_eval) r_out <= n_out;
        else if (i_cmd.commit) r_out.retry_delay_ms <= r_base - r_rem;
    end

    // backoff doubling, one shift per cycle
    logic bo_fin;
    assign bo_fin = (r_bo_i >= r_bo_n) || (r_bo >= {1'b0, r_bmax}) || (r_bo == 33'd0);
    always_ff @(posedge i_clk) begin
        if (i_cmd.bo_start) begin
            r_bo   <= {1'b0, r_bmin};
            r_bo_i <= 8'd1;
            r_bo_n <= (r_att == 8'd0) ? 8'd1 : r_att;
        end else if (i_cmd.bo_step) begin
            r_bo   <= r_bo << 1;
            r_bo_i <= r_bo_i + 8'd1;
        end
    end

    // restoring remainder of random_word by (base/4 + 1), one bit per cycle
    logic [31:0] base_c;
    logic [32:0] trial;
    assign base_c = (r_bo > {1'b0, r_bmax}) ? r_bmax : r_bo[31:0];
    assign trial  = {r_rem, r_dq[31]};
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_base <= base_c;
            r_win1 <= {2'b00, base_c[31:2]} + 32'd1;
            r_rem  <= '0;
            r_dq   <= r_in.random_word;
            r_dcnt <= (base_c[31:2] == 30'd0) ? 6'd32 : 6'd0;
        end else if (i_cmd.div_step) begin
            r_dq   <= r_dq << 1;
            r_dcnt <= r_dcnt + 6'd1;
            if (trial >= {1'b0, r_win1}) r_rem <= 32'(trial - {1'b0, r_win1});
            else r_rem <= trial[31:0];
        end
    end

    assign o_sts.need_retry = n_need;
    assign o_sts.bo_done    = bo_fin;
    assign o_sts.div_done   = r_dcnt[5];
    assign o_out            = r_out;
endmodule

@@ rtl/link_reconnect_backoff_controller.sv @@
// Sequence: an accepted item is evaluated and its result presented; a retry
// first runs the backoff doubling and a bit-serial jitter remainder.
// Throughput: one item at a time; a new item is taken only in idle.
// Reset: synchronous active-low; state and config registers get reset values.
// -----------------------------------------------------------------------------
// link_reconnect_backoff_controller
// Reconnect controller with exponential backoff and jitter.
// -----------------------------------------------------------------------------
module link_reconnect_backoff_controller import lrbc_pkg::*; #(
    parameter int TIMER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);
    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lrbc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    lrbc_datapath #(.TIMER_BITS(TIMER_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in(i_in_data), .i_cmd(w_cmd), .o_sts(w_sts), .o_out(o_out_data)
    );
endmodule
